// ----- hw/rtl/pes_header_field_parser_core_assert.svh -----
// ----------------------------------------------------------------------------
// PES header parser assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PES_HEADER_FIELD_PARSER_CORE_ASSERT_SVH
`define PES_HEADER_FIELD_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PESP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pesp check failed");
`define PESP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pesp check failed");
`else
`define PESP_ASSERT_NOW(lbl, ante, cons)
`define PESP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/pesp_pkg.sv -----
// ----------------------------------------------------------------------------
// PES header parser package
// Phase codes, field codes, result types and phase sequencing helpers.
// ----------------------------------------------------------------------------
package pesp_pkg;

	typedef enum logic [4:0] {
		PH_IDLE, PH_FLAGS2, PH_HDRLEN, PH_PTS, PH_DTS, PH_ESCR, PH_ESRATE,
		PH_TRICK, PH_COPY, PH_CRC, PH_EXTFLAGS, PH_PRIV, PH_PACKLEN, PH_PACK,
		PH_SEQ, PH_PSTD, PH_EXT2LEN, PH_EXT2DATA, PH_STUFF, PH_PAYLOAD
	} phase_t;

	typedef enum logic [4:0] {
		FC_FLAGS1, FC_FLAGS2, FC_HDRLEN, FC_PTS, FC_DTS, FC_ESCR_BASE,
		FC_ESCR_EXT, FC_ES_RATE, FC_TRICK_CTRL, FC_TRICK_DETAIL, FC_COPY_INFO,
		FC_PREV_CRC, FC_EXT_FLAGS, FC_PRIV_DATA, FC_PACK_LEN, FC_PACK_BYTE,
		FC_SEQ_CNT, FC_MPEG_ID, FC_STUFF_LEN, FC_PSTD_SCALE, FC_PSTD_SIZE,
		FC_EXT2_LEN, FC_EXT2_SID, FC_EXT2_RSVD, FC_STUFFING, FC_PRIV1_PAYLOAD,
		FC_PAYLOAD
	} fcode_t;

	localparam logic [7:0] STUFF_BYTE   = 8'hFF;
	localparam logic [7:0] SID_PRIV1    = 8'hBD;
	localparam logic [3:0] PTS_ONLY_PFX = 4'h2;
	localparam logic [3:0] PTS_DTS_PFX  = 4'h3;
	localparam logic [3:0] DTS_PFX      = 4'h1;
	localparam logic [7:0] PRIV_LEN     = 8'd16;
	localparam int         NSLOT        = 3;

	typedef struct packed {
		logic [4:0]  code;
		logic [32:0] value;
		logic        merr;
		logic        lerr;
	} res_t;

	typedef struct packed {
		res_t [NSLOT-1:0] slot;
		logic [1:0]       n;
	} bundle_t;

	function automatic phase_t next_phase(input phase_t from, input logic [7:0] f2,
			input logic [7:0] e);
		logic [19:0] en;
		phase_t      res;
		en              = '0;
		en[PH_PTS]      = f2[7];
		en[PH_DTS]      = f2[7] & f2[6];
		en[PH_ESCR]     = f2[5];
		en[PH_ESRATE]   = f2[4];
		en[PH_TRICK]    = f2[3];
		en[PH_COPY]     = f2[2];
		en[PH_CRC]      = f2[1];
		en[PH_EXTFLAGS] = f2[0];
		en[PH_PRIV]     = e[7];
		en[PH_PACKLEN]  = e[6];
		en[PH_SEQ]      = e[5];
		en[PH_PSTD]     = e[4];
		en[PH_EXT2LEN]  = e[0];
		res = PH_STUFF;
		for (int i = PH_EXT2LEN; i >= PH_PTS; i--) begin
			if (en[i] && (5'(i) > from)) begin
				res = phase_t'(5'(i));
			end
		end
		return res;
	endfunction

	function automatic logic [4:0] trunc_code(input phase_t ph);
		logic [4:0] c;
		case (ph)
			PH_FLAGS2:   c = FC_FLAGS2;
			PH_HDRLEN:   c = FC_HDRLEN;
			PH_PTS:      c = FC_PTS;
			PH_DTS:      c = FC_DTS;
			PH_ESCR:     c = FC_ESCR_BASE;
			PH_ESRATE:   c = FC_ES_RATE;
			PH_TRICK:    c = FC_TRICK_CTRL;
			PH_COPY:     c = FC_COPY_INFO;
			PH_CRC:      c = FC_PREV_CRC;
			PH_EXTFLAGS: c = FC_EXT_FLAGS;
			PH_PRIV:     c = FC_PRIV_DATA;
			PH_PACKLEN:  c = FC_PACK_LEN;
			PH_PACK:     c = FC_PACK_BYTE;
			PH_SEQ:      c = FC_MPEG_ID;
			PH_PSTD:     c = FC_PSTD_SCALE;
			PH_EXT2LEN:  c = FC_EXT2_LEN;
			PH_EXT2DATA: c = FC_EXT2_RSVD;
			PH_STUFF:    c = FC_STUFFING;
			PH_PAYLOAD:  c = FC_PAYLOAD;
			default:     c = FC_FLAGS1;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/pesp_if.sv -----
// ----------------------------------------------------------------------------
// PES header parser channels
// Valid/ready channels for packet bytes in and field items out.
// ----------------------------------------------------------------------------
interface pesp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	logic [7:0] stream_id;
	modport source (output valid, data_byte, first_byte, last_byte, stream_id,
		input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, stream_id,
		output ready);
endinterface

interface pesp_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  field_code;
	logic [32:0] field_value;
	logic        marker_error;
	logic        length_error;
	logic        last_in_run;
	modport source (output valid, field_code, field_value, marker_error,
		length_error, last_in_run, input ready);
	modport sink (input valid, field_code, field_value, marker_error,
		length_error, last_in_run, output ready);
endinterface

// ----- hw/rtl/pesp_parse.sv -----
// ----------------------------------------------------------------------------
// PES header parser step
// Parse state registers and the per-byte decode into a result bundle.
// ----------------------------------------------------------------------------
module pesp_parse
	import pesp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] b,
	input  logic       first,
	input  logic       last,
	input  logic [7:0] sid,
	output bundle_t    bundle
);

	phase_t      ph_q, ph_n, go_from;
	logic [3:0]  bif_q, bif_n;
	logic [15:0] hf_q, hf_n;
	logic [7:0]  ef_q, ef_n;
	logic [7:0]  hl_q, hl_n;
	logic [7:0]  sub_q, sub_n;
	logic [47:0] acc_q, acc_n;
	logic [7:0]  sid_q, sid_n;
	logic        do_go;
	logic [3:0]  want;
	res_t [NSLOT-1:0] r;
	logic [1:0]  n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			bif_q <= '0;
			hf_q  <= '0;
			ef_q  <= '0;
			hl_q  <= '0;
			sub_q <= '0;
			acc_q <= '0;
			sid_q <= '0;
		end else if (adv) begin
			ph_q  <= ph_n;
			bif_q <= bif_n;
			hf_q  <= hf_n;
			ef_q  <= ef_n;
			hl_q  <= hl_n;
			sub_q <= sub_n;
			acc_q <= acc_n;
			sid_q <= sid_n;
		end
	end

	always_comb begin
		ph_n = ph_q; bif_n = bif_q; hf_n = hf_q; ef_n = ef_q;
		hl_n = hl_q; sub_n = sub_q; acc_n = acc_q; sid_n = sid_q;
		do_go = 1'b0; go_from = ph_q; want = '0;
		r = '0; n = 2'd0;
		if (first) begin
			bif_n = '0; ef_n = '0; hl_n = '0; sub_n = '0; acc_n = '0;
			sid_n = sid;
			hf_n = {b, 8'h00};
			r[0] = '{FC_FLAGS1, {25'd0, b}, b[7:6] != 2'b10, 1'b0};
			n = 2'd1;
			ph_n = PH_FLAGS2;
		end else if (ph_q == PH_IDLE) begin
			n = 2'd0;
		end else if (ph_q == PH_FLAGS2) begin
			hf_n[7:0] = b;
			r[0] = '{FC_FLAGS2, {25'd0, b}, 1'b0, 1'b0};
			n = 2'd1;
			ph_n = PH_HDRLEN;
		end else if (ph_q == PH_HDRLEN) begin
			r[0] = '{FC_HDRLEN, {25'd0, b}, 1'b0, 1'b0};
			n = 2'd1;
			hl_n = b;
			do_go = 1'b1;
		end else if (ph_q >= PH_PAYLOAD) begin
			r[0] = '{(sid_q == SID_PRIV1) ? FC_PRIV1_PAYLOAD : FC_PAYLOAD,
				{25'd0, b}, 1'b0, 1'b0};
			n = 2'd1;
		end else begin
			if (hl_q != 8'd0) hl_n = hl_q - 8'd1;
			acc_n = {acc_q[39:0], b};
			bif_n = bif_q + 4'd1;
			case (ph_q)
				PH_PTS, PH_DTS: begin
					want = (ph_q == PH_DTS) ? DTS_PFX :
						((hf_q[7:6] == 2'b11) ? PTS_DTS_PFX : PTS_ONLY_PFX);
					if (bif_n >= 4'd5) begin
						r[0] = '{(ph_q == PH_DTS) ? FC_DTS : FC_PTS,
							{acc_n[35:33], acc_n[31:17], acc_n[15:1]},
							(acc_n[39:36] != want) | ~acc_n[32] | ~acc_n[16] | ~acc_n[0],
							1'b0};
						n = 2'd1;
						do_go = 1'b1;
					end
				end
				PH_ESCR: begin
					if (bif_n >= 4'd6) begin
						r[0] = '{FC_ESCR_BASE, {acc_n[45:43], acc_n[41:27], acc_n[25:11]},
							~acc_n[42] | ~acc_n[26] | ~acc_n[10], 1'b0};
						r[1] = '{FC_ESCR_EXT, {24'd0, acc_n[9:1]}, ~acc_n[0], 1'b0};
						n = 2'd2;
						do_go = 1'b1;
					end
				end
				PH_ESRATE: begin
					if (bif_n >= 4'd3) begin
						r[0] = '{FC_ES_RATE, {11'd0, acc_n[22:1]}, ~acc_n[23] | ~acc_n[0],
							1'b0};
						n = 2'd1;
						do_go = 1'b1;
					end
				end
				PH_TRICK: begin
					r[0] = '{FC_TRICK_CTRL, {30'd0, b[7:5]}, 1'b0, 1'b0};
					r[1] = '{FC_TRICK_DETAIL, {28'd0, b[4:0]}, 1'b0, 1'b0};
					n = 2'd2;
					do_go = 1'b1;
				end
				PH_COPY: begin
					r[0] = '{FC_COPY_INFO, {26'd0, b[6:0]}, ~b[7], 1'b0};
					n = 2'd1;
					do_go = 1'b1;
				end
				PH_CRC: begin
					if (bif_n >= 4'd2) begin
						r[0] = '{FC_PREV_CRC, {17'd0, acc_n[15:0]}, 1'b0, 1'b0};
						n = 2'd1;
						do_go = 1'b1;
					end
				end
				PH_EXTFLAGS: begin
					ef_n = b;
					r[0] = '{FC_EXT_FLAGS, {25'd0, b}, 1'b0, 1'b0};
					n = 2'd1;
					do_go = 1'b1;
				end
				PH_PRIV, PH_PACK: begin
					r[0] = '{(ph_q == PH_PRIV) ? FC_PRIV_DATA : FC_PACK_BYTE,
						{25'd0, b}, 1'b0, 1'b0};
					n = 2'd1;
					bif_n = bif_q; acc_n = acc_q;
					if (sub_q != 8'd0) sub_n = sub_q - 8'd1;
					if (sub_n == 8'd0) do_go = 1'b1;
				end
				PH_PACKLEN: begin
					r[0] = '{FC_PACK_LEN, {25'd0, b}, 1'b0, 1'b0};
					n = 2'd1;
					bif_n = bif_q; acc_n = acc_q;
					if (b != 8'd0) begin
						ph_n = PH_PACK;
						sub_n = b;
					end else begin
						do_go = 1'b1;
						go_from = PH_PACK;
					end
				end
				PH_SEQ: begin
					acc_n = acc_q;
					if (bif_q == 4'd0) begin
						r[0] = '{FC_SEQ_CNT, {26'd0, b[6:0]}, ~b[7], 1'b0};
						n = 2'd1;
						bif_n = 4'd1;
					end else begin
						r[0] = '{FC_MPEG_ID, {32'd0, b[6]}, ~b[7], 1'b0};
						r[1] = '{FC_STUFF_LEN, {27'd0, b[5:0]}, 1'b0, 1'b0};
						n = 2'd2;
						do_go = 1'b1;
					end
				end
				PH_PSTD: begin
					if (bif_n >= 4'd2) begin
						r[0] = '{FC_PSTD_SCALE, {32'd0, acc_n[13]}, acc_n[15:14] != 2'b01,
							1'b0};
						r[1] = '{FC_PSTD_SIZE, {20'd0, acc_n[12:0]}, 1'b0, 1'b0};
						n = 2'd2;
						do_go = 1'b1;
					end
				end
				PH_EXT2LEN: begin
					r[0] = '{FC_EXT2_LEN, {26'd0, b[6:0]}, ~b[7], 1'b0};
					n = 2'd1;
					acc_n = acc_q;
					if (b[6:0] != 7'd0) begin
						ph_n = PH_EXT2DATA;
						sub_n = {1'b0, b[6:0]};
						bif_n = 4'd0;
					end else begin
						bif_n = bif_q;
						do_go = 1'b1;
						go_from = PH_EXT2DATA;
					end
				end
				PH_EXT2DATA: begin
					r[0] = '{(bif_q == 4'd0) ? FC_EXT2_SID : FC_EXT2_RSVD,
						{25'd0, b}, 1'b0, 1'b0};
					n = 2'd1;
					acc_n = acc_q;
					bif_n = 4'd1;
					if (sub_q != 8'd0) sub_n = sub_q - 8'd1;
					if (sub_n == 8'd0) do_go = 1'b1;
				end
				default: begin
					r[0] = '{FC_STUFFING, {25'd0, b}, b != STUFF_BYTE, 1'b0};
					n = 2'd1;
					bif_n = bif_q; acc_n = acc_q;
				end
			endcase
		end
		if (do_go) begin
			ph_n  = next_phase(go_from, hf_n[7:0], ef_n);
			bif_n = '0;
			acc_n = '0;
			sub_n = (ph_n == PH_PRIV) ? PRIV_LEN : 8'd0;
		end
		if (!first && ph_q >= PH_HDRLEN && ph_q < PH_PAYLOAD && hl_n == 8'd0) begin
			if (ph_n >= PH_PTS && ph_n <= PH_EXT2DATA) begin
				if (n != 2'd0) begin
					r[n - 2'd1].lerr = 1'b1;
				end else begin
					r[0] = '{trunc_code(ph_n), 33'd0, 1'b0, 1'b1};
					n = 2'd1;
				end
			end
			ph_n = PH_PAYLOAD;
		end
		if (last && ph_q != PH_IDLE || last && first) begin
			if (ph_n >= PH_FLAGS2 && ph_n <= PH_STUFF) begin
				if (n != 2'd0) begin
					r[n - 2'd1].lerr = 1'b1;
				end else begin
					r[0] = '{trunc_code(ph_n), 33'd0, 1'b0, 1'b1};
					n = 2'd1;
				end
			end
			ph_n = PH_IDLE;
		end
		bundle.slot = r;
		bundle.n    = n;
	end

endmodule

// ----- hw/rtl/pesp_outq.sv -----
// ----------------------------------------------------------------------------
// PES header parser result queue
// Holds one byte's result bundle and hands it out one item at a time.
// ----------------------------------------------------------------------------
module pesp_outq
	import pesp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  bundle_t    bundle,
	output logic       free,
	pesp_out_if.source out_ch
);

	res_t [NSLOT-1:0] slot_q;
	logic [1:0]       cnt_q;
	logic             take;

	assign take = out_ch.valid & out_ch.ready;
	assign free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= bundle.slot;
		end else if (take) begin
			slot_q <= {slot_q[NSLOT-1], slot_q[NSLOT-1:1]};
		end
	end

	assign out_ch.valid        = cnt_q != 2'd0;
	assign out_ch.field_code   = slot_q[0].code;
	assign out_ch.field_value  = slot_q[0].value;
	assign out_ch.marker_error = slot_q[0].merr;
	assign out_ch.length_error = slot_q[0].lerr;
	assign out_ch.last_in_run  = cnt_q == 2'd1;

endmodule

// ----- hw/rtl/pes_header_field_parser_core.sv -----
// ----------------------------------------------------------------------------
// PES header field parser
// Decodes PES optional header fields into coded field items.
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle when it yields at most one field item
// and the receiver is ready for each item; a byte that completes two items
// (ESCR, trick mode, sequence counter, P-STD) holds the input while the result
// queue drains. A byte passes through the input register, then is decoded
// into the result queue.
`include "pes_header_field_parser_core_assert.svh"

module pes_header_field_parser_core
	import pesp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pesp_in_if.sink    in_ch,
	pesp_out_if.source out_ch
);

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;
	logic [7:0] sid_s1;
	logic       adv;
	logic       free;
	bundle_t    bundle;

	assign adv         = vld_s1 & free;
	assign in_ch.ready = ~vld_s1 | free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1  <= in_ch.data_byte;
			first_s1 <= in_ch.first_byte;
			last_s1  <= in_ch.last_byte;
			sid_s1   <= in_ch.stream_id;
		end
	end

	pesp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.b      (byte_s1),
		.first  (first_s1),
		.last   (last_s1),
		.sid    (sid_s1),
		.bundle (bundle)
	);

	pesp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.bundle (bundle),
		.free   (free),
		.out_ch (out_ch)
	);

	`PESP_ASSERT_NEXT(a_hold_s1, vld_s1 && !free, vld_s1)
	`PESP_ASSERT_NEXT(a_result_shown, adv && bundle.n != 2'd0, out_ch.valid)
	`PESP_ASSERT_NOW(a_code_range, out_ch.valid, out_ch.field_code <= FC_PAYLOAD)

endmodule

// ----- dv/pes_header_field_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// PES header field parser testbench
// Feeds directed and random PES packets into the parser under random idling
// and one long receiver hold-off. A built-in field predictor produces the
// expected items, and each output item is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pes_header_field_parser_core_tb;
	import pesp_pkg::*;

	localparam int CYCLE_LIMIT = 250000;

	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [7:0] sid;
	} pes_byte_t;

	typedef struct {
		logic [4:0]  code;
		logic [32:0] value;
		logic        merr;
		logic        lerr;
		logic        last;
	} field_item_t;

	logic clk;
	logic arst_n;

	pesp_in_if  in_ch ();
	pesp_out_if out_ch ();

	pes_header_field_parser_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pes_byte_t   byte_q[$];
	field_item_t field_q[$];
	field_item_t run_buf[3];
	int          run_n;

	phase_t      ph;
	logic [3:0]  bif;
	logic [15:0] hflags;
	logic [7:0]  eflags;
	logic [7:0]  hdr_left;
	logic [7:0]  sub_left;
	logic [47:0] acc;
	logic [2:0]  trick_ctl;
	logic [7:0]  sid_held;

	int  errors;
	int  cycles;
	int  bytes_sent;
	int  fields_checked;
	int  packets;
	int  in_gap;
	int  rx_wait;
	int  hold;
	bit  held_once;
	bit  burst;
	bit  in_took;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------ predictor
	function automatic bit field_on(phase_t p);
		case (p)
			PH_PTS:      return hflags[7];
			PH_DTS:      return hflags[7] & hflags[6];
			PH_ESCR:     return hflags[5];
			PH_ESRATE:   return hflags[4];
			PH_TRICK:    return hflags[3];
			PH_COPY:     return hflags[2];
			PH_CRC:      return hflags[1];
			PH_EXTFLAGS: return hflags[0];
			PH_PRIV:     return eflags[7];
			PH_PACKLEN:  return eflags[6];
			PH_SEQ:      return eflags[5];
			PH_PSTD:     return eflags[4];
			PH_EXT2LEN:  return eflags[0];
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic [4:0] cut_code(phase_t p);
		case (p)
			PH_FLAGS2:   return FC_FLAGS2;
			PH_HDRLEN:   return FC_HDRLEN;
			PH_PTS:      return FC_PTS;
			PH_DTS:      return FC_DTS;
			PH_ESCR:     return FC_ESCR_BASE;
			PH_ESRATE:   return FC_ES_RATE;
			PH_TRICK:    return FC_TRICK_CTRL;
			PH_COPY:     return FC_COPY_INFO;
			PH_CRC:      return FC_PREV_CRC;
			PH_EXTFLAGS: return FC_EXT_FLAGS;
			PH_PRIV:     return FC_PRIV_DATA;
			PH_PACKLEN:  return FC_PACK_LEN;
			PH_PACK:     return FC_PACK_BYTE;
			PH_SEQ:      return FC_MPEG_ID;
			PH_PSTD:     return FC_PSTD_SCALE;
			PH_EXT2LEN:  return FC_EXT2_LEN;
			PH_EXT2DATA: return FC_EXT2_RSVD;
			PH_STUFF:    return FC_STUFFING;
			PH_PAYLOAD:  return FC_PAYLOAD;
			default:     return FC_FLAGS1;
		endcase
	endfunction

	function automatic logic [32:0] stamp(logic [47:0] a, int hi, int mid, int lo);
		logic [63:0] w;
		w = 64'(a);
		return 33'((((w >> hi) & 64'h7) << 30) | (((w >> mid) & 64'h7FFF) << 15) |
			((w >> lo) & 64'h7FFF));
	endfunction

	task automatic put(logic [4:0] c, logic [32:0] v, bit m);
		if (run_n < 3) begin
			run_buf[run_n] = '{c, v, m, 1'b0, 1'b0};
			run_n++;
		end
	endtask

	task automatic advance(phase_t from);
		bit found;
		found = 0;
		ph = PH_STUFF;
		for (int p = int'(from) + 1; p <= int'(PH_EXT2LEN); p++) begin
			if (!found && field_on(phase_t'(p))) begin
				ph = phase_t'(p);
				found = 1;
			end
		end
		bif = '0;
		acc = '0;
		sub_left = (ph == PH_PRIV) ? PRIV_LEN : 8'd0;
	endtask

	function automatic bit gather(logic [7:0] b, int need);
		acc = {acc[39:0], b};
		bif = bif + 4'd1;
		return bif >= need;
	endfunction

	task automatic cut_header();
		if (run_n > 0) begin
			run_buf[run_n-1].lerr = 1'b1;
		end else begin
			put(cut_code(ph), '0, 1'b0);
			run_buf[0].lerr = 1'b1;
		end
	endtask

	function automatic bit in_fields();
		return ph >= PH_PTS && ph <= PH_EXT2DATA;
	endfunction

	task automatic take_header_byte(logic [7:0] b);
		logic [3:0] want;
		case (ph)
			PH_PTS, PH_DTS: begin
				if (gather(b, 5)) begin
					want = (ph == PH_DTS) ? DTS_PFX :
						(hflags[7:6] == 2'b11 ? PTS_DTS_PFX : PTS_ONLY_PFX);
					put(ph == PH_DTS ? FC_DTS : FC_PTS, stamp(acc, 33, 17, 1),
						acc[39:36] != want || !acc[32] || !acc[16] || !acc[0]);
					advance(ph);
				end
			end
			PH_ESCR: begin
				if (gather(b, 6)) begin
					put(FC_ESCR_BASE, stamp(acc, 43, 27, 11), !acc[42] || !acc[26] || !acc[10]);
					put(FC_ESCR_EXT, 33'(acc[9:1]), !acc[0]);
					advance(ph);
				end
			end
			PH_ESRATE: begin
				if (gather(b, 3)) begin
					put(FC_ES_RATE, 33'(acc[22:1]), !acc[23] || !acc[0]);
					advance(ph);
				end
			end
			PH_TRICK: begin
				trick_ctl = b[7:5];
				put(FC_TRICK_CTRL, 33'(trick_ctl), 1'b0);
				put(FC_TRICK_DETAIL, 33'(b[4:0]), 1'b0);
				advance(ph);
			end
			PH_COPY: begin
				put(FC_COPY_INFO, 33'(b[6:0]), !b[7]);
				advance(ph);
			end
			PH_CRC: begin
				if (gather(b, 2)) begin
					put(FC_PREV_CRC, 33'(acc[15:0]), 1'b0);
					advance(ph);
				end
			end
			PH_EXTFLAGS: begin
				eflags = b;
				put(FC_EXT_FLAGS, 33'(b), 1'b0);
				advance(ph);
			end
			PH_PRIV, PH_PACK: begin
				put(ph == PH_PRIV ? FC_PRIV_DATA : FC_PACK_BYTE, 33'(b), 1'b0);
				if (sub_left > 0) sub_left--;
				if (sub_left == 0) advance(ph);
			end
			PH_PACKLEN: begin
				put(FC_PACK_LEN, 33'(b), 1'b0);
				if (b != 0) begin
					ph = PH_PACK;
					sub_left = b;
				end else begin
					advance(PH_PACK);
				end
			end
			PH_SEQ: begin
				if (bif == 0) begin
					put(FC_SEQ_CNT, 33'(b[6:0]), !b[7]);
					bif = 4'd1;
				end else begin
					put(FC_MPEG_ID, 33'(b[6]), !b[7]);
					put(FC_STUFF_LEN, 33'(b[5:0]), 1'b0);
					advance(ph);
				end
			end
			PH_PSTD: begin
				if (gather(b, 2)) begin
					put(FC_PSTD_SCALE, 33'(acc[13]), acc[15:14] != 2'b01);
					put(FC_PSTD_SIZE, 33'(acc[12:0]), 1'b0);
					advance(ph);
				end
			end
			PH_EXT2LEN: begin
				put(FC_EXT2_LEN, 33'(b[6:0]), !b[7]);
				if (b[6:0] != 0) begin
					ph = PH_EXT2DATA;
					sub_left = {1'b0, b[6:0]};
					bif = '0;
				end else begin
					advance(PH_EXT2DATA);
				end
			end
			PH_EXT2DATA: begin
				put(bif == 0 ? FC_EXT2_SID : FC_EXT2_RSVD, 33'(b), 1'b0);
				bif = 4'd1;
				if (sub_left > 0) sub_left--;
				if (sub_left == 0) advance(ph);
			end
			default: put(FC_STUFFING, 33'(b), b != STUFF_BYTE);
		endcase
	endtask

	task automatic predict_fields(logic [7:0] b, logic first, logic last, logic [7:0] sid);
		run_n = 0;
		if (first) begin
			bif = '0; eflags = '0; hdr_left = '0; sub_left = '0;
			acc = '0; trick_ctl = '0;
			sid_held = sid;
			hflags = {b, 8'h00};
			put(FC_FLAGS1, 33'(b), b[7:6] != 2'b10);
			ph = PH_FLAGS2;
		end else if (ph == PH_IDLE) begin
			return;
		end else if (ph == PH_FLAGS2) begin
			hflags[7:0] = b;
			put(FC_FLAGS2, 33'(b), 1'b0);
			ph = PH_HDRLEN;
		end else if (ph == PH_HDRLEN) begin
			put(FC_HDRLEN, 33'(b), 1'b0);
			hdr_left = b;
			advance(PH_HDRLEN);
			if (hdr_left == 0) begin
				if (in_fields()) cut_header();
				ph = PH_PAYLOAD;
			end
		end else if (ph == PH_PAYLOAD) begin
			put(sid_held == SID_PRIV1 ? FC_PRIV1_PAYLOAD : FC_PAYLOAD, 33'(b), 1'b0);
		end else begin
			if (hdr_left > 0) hdr_left--;
			take_header_byte(b);
			if (hdr_left == 0) begin
				if (in_fields()) cut_header();
				ph = PH_PAYLOAD;
			end
		end
		if (last) begin
			if (ph >= PH_FLAGS2 && ph <= PH_STUFF) cut_header();
			ph = PH_IDLE;
		end
		for (int k = 0; k < run_n; k++) begin
			run_buf[k].last = (k == run_n - 1);
			field_q.push_back(run_buf[k]);
		end
	endtask

	// ------------------------------------------------------------ stimulus
	function automatic logic [7:0] mark_bit(logic [7:0] v, bit bad);
		return bad ? v : (v | 8'h01);
	endfunction

	task automatic add_packet(logic [7:0] f1, logic [7:0] f2, logic [7:0] e,
			int len_adj, int cut_at, bit corrupt, logic [7:0] sid, int n_stuff,
			int n_pay, bit close);
		logic [7:0]  hdr[$];
		logic [7:0]  pkt[$];
		logic [32:0] ts;
		logic [47:0] w;
		int          n;
		int          len;
		if (f2[7]) begin
			for (int t = 0; t < (f2[6] ? 2 : 1); t++) begin
				ts = 33'({$urandom, $urandom});
				hdr.push_back({t == 1 ? DTS_PFX : (f2[6] ? PTS_DTS_PFX : PTS_ONLY_PFX),
					ts[32:30], 1'b1});
				hdr.push_back(ts[29:22]);
				hdr.push_back({ts[21:15], 1'b1});
				hdr.push_back(ts[14:7]);
				hdr.push_back({ts[6:0], 1'b1});
			end
		end
		if (f2[5]) begin
			ts = 33'({$urandom, $urandom});
			w = {2'($urandom), ts[32:30], 1'b1, ts[29:15], 1'b1, ts[14:0], 1'b1,
				9'($urandom), 1'b1};
			for (int i = 5; i >= 0; i--) hdr.push_back(w[i*8 +: 8]);
		end
		if (f2[4]) begin
			w = {24'h0, 1'b1, 22'($urandom), 1'b1};
			for (int i = 2; i >= 0; i--) hdr.push_back(w[i*8 +: 8]);
		end
		if (f2[3]) hdr.push_back(8'($urandom));
		if (f2[2]) hdr.push_back({1'b1, 7'($urandom)});
		if (f2[1]) begin
			hdr.push_back(8'($urandom));
			hdr.push_back(8'($urandom));
		end
		if (f2[0]) begin
			hdr.push_back(e);
			if (e[7]) for (int i = 0; i < 16; i++) hdr.push_back(8'($urandom));
			if (e[6]) begin
				n = $urandom_range(0, 3);
				hdr.push_back(8'(n));
				for (int i = 0; i < n; i++) hdr.push_back(8'($urandom));
			end
			if (e[5]) begin
				hdr.push_back({1'b1, 7'($urandom)});
				hdr.push_back({1'b1, 7'($urandom)});
			end
			if (e[4]) begin
				hdr.push_back({2'b01, 6'($urandom)});
				hdr.push_back(8'($urandom));
			end
			if (e[0]) begin
				n = $urandom_range(0, 3);
				hdr.push_back({1'b1, 7'(n)});
				for (int i = 0; i < n; i++) hdr.push_back(8'($urandom));
			end
		end
		for (int i = 0; i < n_stuff; i++) hdr.push_back(STUFF_BYTE);
		len = hdr.size() + len_adj;
		if (len < 0) len = 0;
		if (len > 255) len = 255;
		pkt.push_back(f1);
		pkt.push_back(f2);
		pkt.push_back(8'(len));
		pkt = {pkt, hdr};
		for (int i = 0; i < n_pay; i++) pkt.push_back(8'($urandom));
		if (corrupt) begin
			n = $urandom_range(0, pkt.size() - 1);
			pkt[n][$urandom_range(0, 7)] ^= 1'b1;
		end
		if (cut_at > 0 && cut_at < pkt.size()) pkt = pkt[0:cut_at-1];
		foreach (pkt[i])
			byte_q.push_back('{pkt[i], i == 0, close && i == pkt.size() - 1,
				i == 0 ? sid : 8'($urandom)});
		packets++;
	endtask

	task automatic add_noise(int n);
		for (int i = 0; i < n; i++)
			byte_q.push_back('{8'($urandom), 1'b0, 1'($urandom), 8'($urandom)});
	endtask

	task automatic add_random_packet();
		logic [7:0] f1;
		logic [7:0] f2;
		logic [7:0] e;
		logic [7:0] sid;
		int         adj;
		f1 = ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
		f2 = 8'($urandom);
		e = 8'($urandom);
		if ($urandom_range(0, 3) != 0) e[7] = 1'b0;
		adj = ($urandom_range(0, 5) == 0) ? -$urandom_range(1, 6) : 0;
		sid = ($urandom_range(0, 2) == 0) ? SID_PRIV1 : 8'($urandom);
		add_packet(f1, f2, e, adj,
			($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0,
			$urandom_range(0, 4) == 0, sid, $urandom_range(0, 3),
			$urandom_range(0, 4), $urandom_range(0, 9) != 0);
		if ($urandom_range(0, 9) == 0) add_noise($urandom_range(1, 3));
	endtask

	// ------------------------------------------------------------ driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_took) begin
				// hold current item
			end else if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				pes_byte_t it;
				it = byte_q.pop_front();
				in_ch.valid      <= 1'b1;
				in_ch.data_byte  <= it.data;
				in_ch.first_byte <= it.first;
				in_ch.last_byte  <= it.last;
				in_ch.stream_id  <= it.sid;
				if (bytes_sent % 64 == 0) burst = $urandom_range(0, 2) == 0;
				in_gap = (burst || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 12);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------ receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (fields_checked >= 80 && !held_once) begin
				hold <= 300;
				held_once <= 1'b1;
			end else if (hold > 0) begin
				hold <= hold - 1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_wait > 0) begin
				rx_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= (hold == 0);
			end
		end
	end

	// ------------------------------------------------------------ monitor
	always @(posedge clk) begin
		field_item_t exp;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d items outstanding", $time, field_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
		in_took = arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			fields_checked++;
			rx_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
			if (field_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item code=%0d value=%h", $time,
					out_ch.field_code, out_ch.field_value);
			end else begin
				exp = field_q.pop_front();
				if (out_ch.field_code !== exp.code || out_ch.field_value !== exp.value ||
						out_ch.marker_error !== exp.merr || out_ch.length_error !== exp.lerr ||
						out_ch.last_in_run !== exp.last) begin
					errors++;
					$display("%0t mismatch exp code=%0d val=%h m=%b l=%b last=%b",
						$time, exp.code, exp.value, exp.merr, exp.lerr, exp.last);
					$display("%0t          got code=%0d val=%h m=%b l=%b last=%b",
						$time, out_ch.field_code, out_ch.field_value, out_ch.marker_error,
						out_ch.length_error, out_ch.last_in_run);
				end
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			bytes_sent++;
			predict_fields(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte,
				in_ch.stream_id);
		end
	end

	// ------------------------------------------------------------ sequence
	initial begin
		errors = 0; cycles = 0; bytes_sent = 0; fields_checked = 0; packets = 0;
		in_gap = 0; rx_wait = 0; hold = 0; held_once = 0; burst = 0; in_took = 0;
		ph = PH_IDLE; bif = '0; hflags = '0; eflags = '0; hdr_left = '0;
		sub_left = '0; acc = '0; trick_ctl = '0; sid_held = '0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.first_byte = 1'b0;
		in_ch.last_byte = 1'b0;
		in_ch.stream_id = '0;
		out_ch.ready = 1'b0;

		add_noise(3);
		add_packet(8'h84, 8'hFF, 8'h71, 0, 0, 0, 8'hE0, 1, 1, 1);
		add_packet(8'hBF, 8'h40, 8'h00, 0, 0, 0, SID_PRIV1, 0, 2, 1);
		add_packet(8'h80, 8'hC0, 8'h00, -4, 0, 0, 8'hC0, 0, 1, 1);
		add_packet(8'h00, 8'h00, 8'h00, 0, 0, 0, 8'hFF, 0, 1, 1);
		add_packet(8'h80, 8'h80, 8'h00, 0, 5, 0, 8'h00, 0, 0, 1);
		add_packet(8'h80, 8'h31, 8'h90, 0, 0, 0, 8'hBD, 2, 0, 0);
		add_packet(8'h80, 8'h00, 8'h00, 0, 0, 1, 8'hE0, 2, 1, 1);
		while (byte_q.size() < 320) add_random_packet();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() > 0 || in_ch.valid || field_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (field_q.size() > 0) errors++;

		$display("Covered %0d packets, %0d bytes accepted, %0d field items checked,",
			packets, bytes_sent, fields_checked);
		$display("including truncated headers, marker faults and a long output hold-off.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pesp_pkg.sv
hw/rtl/pesp_if.sv
hw/rtl/pesp_parse.sv
hw/rtl/pesp_outq.sv
hw/rtl/pes_header_field_parser_core.sv
dv/pes_header_field_parser_core_tb.sv
